### src/wdws_pkg.sv
// shared types and constants for the weight driven watering sequencer
`timescale 1ns / 1ps

package wdws_pkg;

  localparam int WEIGHT_BITS = 16;
  localparam int TIME_BITS   = 16;
  localparam int DATA_BITS   = 32;
  localparam int ADDR_BITS   = 5;
  localparam int MAX_CHAIN   = 4;
  localparam int CHG_BITS    = $clog2(MAX_CHAIN + 1);

  // register reset values
  localparam logic [WEIGHT_BITS-1:0] EVAP_RST      = WEIGHT_BITS'(1000);
  localparam logic [WEIGHT_BITS-1:0] DRAIN_TGT_RST = WEIGHT_BITS'(200);
  localparam logic [WEIGHT_BITS-1:0] INCR_RST      = WEIGHT_BITS'(500);
  localparam logic [WEIGHT_BITS-1:0] START_RST     = WEIGHT_BITS'(5000);
  localparam logic [WEIGHT_BITS-1:0] MAX_W_RST     = WEIGHT_BITS'(20000);
  localparam logic [TIME_BITS-1:0]   DRAIN_WAIT_RST = TIME_BITS'(180);
  localparam logic [TIME_BITS-1:0]   LIMIT_RST      = TIME_BITS'(120);

  // start weight plus evaporation target, saturated
  localparam longint WET_SUM = longint'(START_RST) + longint'(EVAP_RST);
  localparam longint WMAX    = (longint'(1) << WEIGHT_BITS) - 1;
  localparam logic [WEIGHT_BITS-1:0] WET_RST =
    (WET_SUM > WMAX) ? '1 : WEIGHT_BITS'(WET_SUM);

  typedef enum logic [2:0] {
    MODE_DISABLED = 3'd0,
    MODE_DRY      = 3'd1,
    MODE_IDLE     = 3'd2,
    MODE_WATERING = 3'd3,
    MODE_DRAINING = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    REG_EVAP       = 3'd0,
    REG_DRAIN_TGT  = 3'd1,
    REG_INCR       = 3'd2,
    REG_START      = 3'd3,
    REG_MAX_W      = 3'd4,
    REG_DRAIN_WAIT = 3'd5,
    REG_LIMIT      = 3'd6,
    REG_DIS_RST    = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    TGT_CUR,
    TGT_DISABLED,
    TGT_WATERING,
    TGT_IDLE
  } tgt_sel_e;

  typedef enum logic [3:0] {
    CS_IDLE,
    CS_PH_CUR,
    CS_PH_DIS,
    CS_PH_START,
    CS_PH_STOP,
    CS_PH_FIVE,
    CS_ENTER,
    CS_JUDGE,
    CS_DONE
  } ctl_state_e;

  typedef struct packed {
    logic [WEIGHT_BITS-1:0] weight;
    logic                   pump_failed;
    logic                   five_second_mark;
    logic                   disable_req;
    logic                   start_req;
    logic                   stop_req;
  } in_t;

  typedef struct packed {
    logic [2:0]             mode_now;
    logic                   pump_run;
    logic                   pump_disable_pulse;
    logic [WEIGHT_BITS-1:0] dry_threshold;
    logic [WEIGHT_BITS-1:0] wet_level;
  } out_t;

  typedef struct packed {
    logic [WEIGHT_BITS-1:0] evap_target;
    logic [WEIGHT_BITS-1:0] drain_target;
    logic [WEIGHT_BITS-1:0] incr;
    logic [WEIGHT_BITS-1:0] start_weight;
    logic [WEIGHT_BITS-1:0] max_weight;
    logic [TIME_BITS-1:0]   drain_wait;
    logic [TIME_BITS-1:0]   limit;
    logic                   dis_at_rst;
  } cfg_t;

  typedef struct packed {
    logic                   set_dry;
    logic [WEIGHT_BITS-1:0] value;
  } dry_wr_t;

  typedef struct packed {
    logic     load_in;
    logic     tgt_load;
    tgt_sel_e tgt_sel;
    logic     enter;
    logic     judge;
    logic     load_out;
  } dp_cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  tgt_diff;
    logic  next_diff;
    logic  five;
    logic  dis;
    logic  start;
    logic  stop;
  } dp_sts_t;

endpackage

### src/weight_driven_watering_sequencer.sv
// top level of the weight driven watering sequencer
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+--------------------------
//  tick in  | input     | in_valid_i/in_stall_o | in_data_i  (in_t)
//  result   | output    | out_valid_o/out_stall_i | out_data_o (out_t)
//  config   | input     | apb psel/penable/pready | paddr, pwdata, prdata
//
// a tick is accepted, walks the five request phases and then loads the
// result; each evaluation walks its transition chain step by step (enter
// then judge) until it settles or the four-change limit cuts it, since the
// single enter/judge datapath handles one step at a time.
// reset leaves the pot idle with all configuration registers at their default values.
// a stalled result holds in the output register; the next tick is taken
// meanwhile and waits in its last cycle until the register frees up.
`timescale 1ns / 1ps

module weight_driven_watering_sequencer import wdws_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_t                  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_t                 out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  cfg_t    cfg;
  dry_wr_t dry_wr;
  dp_cmd_t cmd;
  dp_sts_t sts;

  wdws_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg_o    (cfg),
    .dry_wr_o (dry_wr)
  );

  wdws_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  wdws_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg),
    .dry_wr_i   (dry_wr),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

  // the pump runs exactly in watering mode
  a_pump_matches_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.pump_run == (out_data_o.mode_now == MODE_WATERING)))
    else $error("pump_run disagrees with mode_now");

  // one request at a time: busy right after an accepted request
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted while another is in work");

  // a new result only appears when the previous one was taken or none waited
  a_result_not_overwritten: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_data_o))
    else $error("waiting result overwritten");

endmodule

### src/wdws_regs.sv
// configuration register file behind the apb port
`timescale 1ns / 1ps

module wdws_regs import wdws_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  output cfg_t                 cfg_o,
  output dry_wr_t              dry_wr_o
);

  cfg_t     cfg_q, cfg_d;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[ADDR_BITS-1:2]);

  always_comb begin
    cfg_d          = cfg_q;
    dry_wr_o.set_dry = 1'b0;
    dry_wr_o.value = pwdata[WEIGHT_BITS-1:0];
    if (wr_en) begin
      case (idx)
        REG_EVAP:       cfg_d.evap_target  = pwdata[WEIGHT_BITS-1:0];
        REG_DRAIN_TGT:  cfg_d.drain_target = pwdata[WEIGHT_BITS-1:0];
        REG_INCR:       cfg_d.incr         = pwdata[WEIGHT_BITS-1:0];
        REG_START: begin
          cfg_d.start_weight = pwdata[WEIGHT_BITS-1:0];
          // a start weight write moves the dry threshold only if the value changed
          dry_wr_o.set_dry = (pwdata[WEIGHT_BITS-1:0] != cfg_q.start_weight);
        end
        REG_MAX_W:      cfg_d.max_weight   = pwdata[WEIGHT_BITS-1:0];
        REG_DRAIN_WAIT: cfg_d.drain_wait   = pwdata[TIME_BITS-1:0];
        REG_LIMIT:      cfg_d.limit        = pwdata[TIME_BITS-1:0];
        REG_DIS_RST:    cfg_d.dis_at_rst   = pwdata[0];
        default:        cfg_d              = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.evap_target  <= EVAP_RST;
      cfg_q.drain_target <= DRAIN_TGT_RST;
      cfg_q.incr         <= INCR_RST;
      cfg_q.start_weight <= START_RST;
      cfg_q.max_weight   <= MAX_W_RST;
      cfg_q.drain_wait   <= DRAIN_WAIT_RST;
      cfg_q.limit        <= LIMIT_RST;
      cfg_q.dis_at_rst   <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (idx)
      REG_EVAP:       prdata = DATA_BITS'(cfg_q.evap_target);
      REG_DRAIN_TGT:  prdata = DATA_BITS'(cfg_q.drain_target);
      REG_INCR:       prdata = DATA_BITS'(cfg_q.incr);
      REG_START:      prdata = DATA_BITS'(cfg_q.start_weight);
      REG_MAX_W:      prdata = DATA_BITS'(cfg_q.max_weight);
      REG_DRAIN_WAIT: prdata = DATA_BITS'(cfg_q.drain_wait);
      REG_LIMIT:      prdata = DATA_BITS'(cfg_q.limit);
      REG_DIS_RST:    prdata = DATA_BITS'(cfg_q.dis_at_rst);
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### src/wdws_dpath.sv
// datapath: pot state, transition judge and result register
`timescale 1ns / 1ps

module wdws_dpath import wdws_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  in_t     in_data_i,
  input  cfg_t    cfg_i,
  input  dry_wr_t dry_wr_i,
  input  dp_cmd_t cmd_i,
  output dp_sts_t sts_o,
  output out_t    out_data_o
);

  in_t                    in_q;
  mode_e                  mode_q, target_q, next_mode, tgt_new;
  logic [WEIGHT_BITS-1:0] dry_q, wet_q, wstart_q, dstart_q;
  logic                   dheld_q, pulse_q;
  logic [TIME_BITS-1:0]   mode_s_q, pon_s_q, wat_s_q;
  out_t                   out_q;

  logic [WEIGHT_BITS-1:0] w, dry_calc;
  logic [TIME_BITS:0]     tsum;
  logic [TIME_BITS-1:0]   total;
  logic                   grow_hit, drain_ok, drain_due, above_floor;

  assign w = in_q.weight;

  // cumulative pump time, saturated
  assign tsum  = {1'b0, wat_s_q} + {1'b0, pon_s_q};
  assign total = tsum[TIME_BITS] ? '1 : tsum[TIME_BITS-1:0];

  assign grow_hit    = ({1'b0, w} >= ({1'b0, wstart_q} + {1'b0, cfg_i.incr}));
  assign drain_ok    = ({1'b0, dstart_q} >= ({1'b0, w} + {1'b0, cfg_i.drain_target}));
  assign drain_due   = (mode_s_q > cfg_i.drain_wait);
  assign above_floor = ({1'b0, w} >= ({1'b0, cfg_i.evap_target} + {1'b0, cfg_i.start_weight}));
  assign dry_calc    = above_floor ? (w - cfg_i.evap_target) : cfg_i.start_weight;

  always_comb begin
    next_mode = mode_q;
    case (mode_q)
      MODE_DRY: begin
        if (w >= wet_q) next_mode = MODE_IDLE;
      end
      MODE_IDLE: begin
        if (!in_q.pump_failed && (w <= dry_q)) next_mode = MODE_WATERING;
      end
      MODE_WATERING: begin
        if (grow_hit) begin
          next_mode = MODE_DRAINING;
        end else if ((total > cfg_i.limit) || in_q.pump_failed) begin
          next_mode = MODE_DRY;
        end else if (w >= cfg_i.max_weight) begin
          next_mode = MODE_IDLE;
        end
      end
      MODE_DRAINING: begin
        if (drain_due) next_mode = drain_ok ? MODE_IDLE : MODE_WATERING;
      end
      default: next_mode = mode_q;
    endcase
  end

  always_comb begin
    case (cmd_i.tgt_sel)
      TGT_CUR:      tgt_new = mode_q;
      TGT_DISABLED: tgt_new = MODE_DISABLED;
      TGT_WATERING: tgt_new = MODE_WATERING;
      TGT_IDLE:     tgt_new = MODE_IDLE;
      default:      tgt_new = mode_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      target_q <= MODE_IDLE;
      dry_q    <= START_RST;
      wet_q    <= WET_RST;
      wstart_q <= '0;
      dstart_q <= '0;
      dheld_q  <= 1'b0;
      pulse_q  <= 1'b0;
      mode_s_q <= '0;
      pon_s_q  <= '0;
      wat_s_q  <= '0;
    end else begin
      if (dry_wr_i.set_dry) dry_q <= dry_wr_i.value;
      if (cmd_i.load_in) begin
        pulse_q  <= 1'b0;
        mode_s_q <= (mode_s_q == '1) ? mode_s_q : mode_s_q + 1'b1;
        pon_s_q  <= (pon_s_q == '1) ? pon_s_q : pon_s_q + 1'b1;
      end
      if (cmd_i.tgt_load) target_q <= tgt_new;
      if (cmd_i.enter) begin
        mode_q   <= target_q;
        mode_s_q <= '0;
        if (target_q == MODE_DISABLED) pulse_q <= 1'b1;
        if (target_q == MODE_WATERING) begin
          wstart_q <= w;
          pon_s_q  <= '0;
        end
        if ((target_q == MODE_DRAINING) && !dheld_q) begin
          dstart_q <= w;
          dheld_q  <= 1'b1;
        end
      end
      if (cmd_i.judge) begin
        target_q <= next_mode;
        if ((mode_q == MODE_WATERING) && grow_hit) wat_s_q <= total;
        // a good drain closes the cycle and learns the wet weight
        if ((mode_q == MODE_DRAINING) && drain_ok) begin
          wet_q    <= w;
          dry_q    <= dry_calc;
          dheld_q  <= 1'b0;
          dstart_q <= '0;
          wat_s_q  <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) in_q <= in_data_i;
    if (cmd_i.load_out) begin
      out_q.mode_now           <= mode_q;
      out_q.pump_run           <= (mode_q == MODE_WATERING);
      out_q.pump_disable_pulse <= pulse_q;
      out_q.dry_threshold      <= dry_q;
      out_q.wet_level          <= wet_q;
    end
  end

  assign sts_o.mode      = mode_q;
  assign sts_o.tgt_diff  = (target_q != mode_q);
  assign sts_o.next_diff = (next_mode != mode_q);
  assign sts_o.five      = in_q.five_second_mark;
  assign sts_o.dis       = in_q.disable_req;
  assign sts_o.start     = in_q.start_req;
  assign sts_o.stop      = in_q.stop_req;
  assign out_data_o      = out_q;

endmodule

### src/wdws_ctrl.sv
// controller: walks the request phases and the transition chain of each tick
`timescale 1ns / 1ps

module wdws_ctrl import wdws_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  logic    out_stall_i,
  output logic    out_valid_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  ctl_state_e          state_q, state_d, ret_q, ret_d;
  logic [CHG_BITS-1:0] chg_q, chg_d;
  logic                out_valid_q, out_valid_d;
  logic                busy_mode;

  assign busy_mode = (sts_i.mode == MODE_WATERING) || (sts_i.mode == MODE_DRAINING);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CS_IDLE;
      ret_q       <= CS_IDLE;
      chg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      chg_q       <= chg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    ret_d        = ret_q;
    chg_d        = chg_q;
    out_valid_d  = out_valid_q && out_stall_i;
    cmd_o        = '0;
    cmd_o.tgt_sel = TGT_CUR;
    case (state_q)
      CS_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = CS_PH_CUR;
        end
      end
      CS_PH_CUR: begin
        state_d = CS_PH_DIS;
        if (busy_mode) begin
          cmd_o.tgt_load = 1'b1;
          cmd_o.tgt_sel  = TGT_CUR;
          chg_d          = '0;
          ret_d          = CS_PH_DIS;
          state_d        = CS_ENTER;
        end
      end
      CS_PH_DIS: begin
        state_d = CS_PH_START;
        if (sts_i.dis && (sts_i.mode != MODE_DISABLED)) begin
          cmd_o.tgt_load = 1'b1;
          cmd_o.tgt_sel  = TGT_DISABLED;
          chg_d          = '0;
          ret_d          = CS_PH_START;
          state_d        = CS_ENTER;
        end
      end
      CS_PH_START: begin
        state_d = CS_PH_STOP;
        if (sts_i.start && !busy_mode) begin
          cmd_o.tgt_load = 1'b1;
          cmd_o.tgt_sel  = TGT_WATERING;
          chg_d          = '0;
          ret_d          = CS_PH_STOP;
          state_d        = CS_ENTER;
        end
      end
      CS_PH_STOP: begin
        state_d = CS_PH_FIVE;
        if (sts_i.stop && (sts_i.mode != MODE_IDLE)) begin
          cmd_o.tgt_load = 1'b1;
          cmd_o.tgt_sel  = TGT_IDLE;
          chg_d          = '0;
          ret_d          = CS_PH_FIVE;
          state_d        = CS_ENTER;
        end
      end
      CS_PH_FIVE: begin
        state_d = CS_DONE;
        if (sts_i.five) begin
          cmd_o.tgt_load = 1'b1;
          cmd_o.tgt_sel  = TGT_CUR;
          chg_d          = '0;
          ret_d          = CS_DONE;
          state_d        = CS_ENTER;
        end
      end
      CS_ENTER: begin
        if (!sts_i.tgt_diff) begin
          state_d = CS_JUDGE;
        end else if (chg_q == CHG_BITS'(MAX_CHAIN)) begin
          // chain limit reached, leave the pending change for later
          state_d = ret_q;
        end else begin
          cmd_o.enter = 1'b1;
          chg_d       = chg_q + 1'b1;
          state_d     = CS_JUDGE;
        end
      end
      CS_JUDGE: begin
        if (sts_i.next_diff) begin
          cmd_o.judge = 1'b1;
          state_d     = CS_ENTER;
        end else begin
          state_d = ret_q;
        end
      end
      CS_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = CS_IDLE;
        end
      end
      default: state_d = CS_IDLE;
    endcase
  end

  assign in_stall_o  = (state_q != CS_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### sim/weight_driven_watering_sequencer_tb.sv
// testbench for the weight driven watering sequencer: directed table, then random ticks
`timescale 1ns / 1ps

module weight_driven_watering_sequencer_tb;
  import wdws_pkg::*;

  typedef logic [WEIGHT_BITS-1:0] grams_t;
  typedef logic [TIME_BITS-1:0]   secs_t;

  typedef struct packed {
    bit                   is_write;
    reg_idx_e             sel;
    logic [DATA_BITS-1:0] value;
    in_t                  tick;
    bit                   typed;
    out_t                 want;
  } plan_row_t;

  // request flag masks, in field order: pump_failed, five, disable, start, stop
  localparam logic [4:0] F_NONE  = 5'b00000;
  localparam logic [4:0] F_FAIL  = 5'b10000;
  localparam logic [4:0] F_FIVE  = 5'b01000;
  localparam logic [4:0] F_DIS   = 5'b00100;
  localparam logic [4:0] F_START = 5'b00010;
  localparam logic [4:0] F_STOP  = 5'b00001;

  localparam out_t AT_REST   = {MODE_IDLE, 1'b0, 1'b0, START_RST, WET_RST};
  localparam out_t OFF_PULSE = {MODE_DISABLED, 1'b0, 1'b1, START_RST, WET_RST};
  localparam out_t OFF_QUIET = {MODE_DISABLED, 1'b0, 1'b0, START_RST, WET_RST};
  localparam out_t FILLING   = {MODE_WATERING, 1'b1, 1'b0, START_RST, WET_RST};
  localparam out_t SOAKING   = {MODE_DRAINING, 1'b0, 1'b0, START_RST, WET_RST};

  localparam int CYCLE_LIMIT  = 800000;
  localparam int PHASES       = 9;
  localparam int PHASE_TICKS  = 150;
  localparam int LONG_HOLD    = 300;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  in_t                  in_data_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  out_t                 out_data_o;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0] pwdata;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  weight_driven_watering_sequencer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // settings mirrored from the register writes
  grams_t set_evap, set_drain, set_incr, set_start, set_max;
  secs_t  set_wait, set_limit;
  logic   set_dis;

  // pot state as the sequencer should hold it
  mode_e  pot_mode;
  grams_t dry_w, wet_w, fill_base, drain_base;
  secs_t  secs_in_mode, pump_secs, pump_total;
  logic   drain_held, pump_flag, dis_pulse;

  out_t   results_due[$];
  bit     tick_typed;
  out_t   tick_want;
  out_t   calc, want;
  bit     steady;
  bit     hold_off_req;
  int     errors;
  int     ticks_sent;
  int     results_checked;
  int     settings_used;
  int     mode_hits[5];
  int     cycle_count;

  // one evaluation toward goal, following chained transitions
  function automatic void settle_mode(mode_e goal, grams_t w, logic failed);
    int unsigned hops;
    mode_e nxt;
    logic [TIME_BITS:0] total;
    bit done;
    hops = 0;
    done = 1'b0;
    while (!done) begin
      if (pot_mode != goal && hops == MAX_CHAIN) begin
        done = 1'b1;
      end else begin
        if (pot_mode != goal) begin
          hops++;
          pot_mode = goal;
          secs_in_mode = '0;
          if (goal == MODE_DISABLED) dis_pulse = 1'b1;
          if (goal == MODE_WATERING) begin
            fill_base = w;
            pump_secs = '0;
          end
          if (goal == MODE_DRAINING && !drain_held) begin
            drain_base = w;
            drain_held = 1'b1;
          end
        end
        nxt = pot_mode;
        case (pot_mode)
          MODE_DRY: begin
            if (w >= wet_w) nxt = MODE_IDLE;
          end
          MODE_IDLE: begin
            if (!failed && w <= dry_w) nxt = MODE_WATERING;
          end
          MODE_WATERING: begin
            total = {1'b0, pump_total} + {1'b0, pump_secs};
            if (total[TIME_BITS]) total = {1'b0, {TIME_BITS{1'b1}}};
            if ({1'b0, w} >= {1'b0, fill_base} + {1'b0, set_incr}) begin
              pump_total = total[TIME_BITS-1:0];
              nxt = MODE_DRAINING;
            end else if (total[TIME_BITS-1:0] > set_limit || failed) begin
              nxt = MODE_DRY;
            end else if (w >= set_max) begin
              nxt = MODE_IDLE;
            end
          end
          MODE_DRAINING: begin
            if (secs_in_mode > set_wait) begin
              // weight above the drain start counts as nothing drained
              if ({1'b0, drain_base} >= {1'b0, w} + {1'b0, set_drain}) begin
                wet_w = w;
                dry_w = ({1'b0, w} >= {1'b0, set_evap} + {1'b0, set_start}) ?
                        w - set_evap : set_start;
                drain_held = 1'b0;
                drain_base = '0;
                pump_total = '0;
                nxt = MODE_IDLE;
              end else begin
                nxt = MODE_WATERING;
              end
            end
          end
          default: ;
        endcase
        if (nxt == pot_mode) done = 1'b1;
        else goal = nxt;
      end
    end
    pump_flag = (pot_mode == MODE_WATERING);
  endfunction

  function automatic out_t advance_pot(in_t t);
    out_t r;
    dis_pulse = 1'b0;
    if (secs_in_mode != '1) secs_in_mode = secs_in_mode + 1'b1;
    if (pump_secs != '1) pump_secs = pump_secs + 1'b1;
    if (pot_mode == MODE_WATERING || pot_mode == MODE_DRAINING)
      settle_mode(pot_mode, t.weight, t.pump_failed);
    if (t.disable_req && pot_mode != MODE_DISABLED)
      settle_mode(MODE_DISABLED, t.weight, t.pump_failed);
    if (t.start_req && pot_mode != MODE_WATERING && pot_mode != MODE_DRAINING)
      settle_mode(MODE_WATERING, t.weight, t.pump_failed);
    if (t.stop_req && pot_mode != MODE_IDLE)
      settle_mode(MODE_IDLE, t.weight, t.pump_failed);
    if (t.five_second_mark) settle_mode(pot_mode, t.weight, t.pump_failed);
    r.mode_now           = pot_mode;
    r.pump_run           = pump_flag;
    r.pump_disable_pulse = dis_pulse;
    r.dry_threshold      = dry_w;
    r.wet_level          = wet_w;
    return r;
  endfunction

  function automatic void apply_setting(reg_idx_e sel, logic [DATA_BITS-1:0] v);
    case (sel)
      REG_EVAP:       set_evap  = v[WEIGHT_BITS-1:0];
      REG_DRAIN_TGT:  set_drain = v[WEIGHT_BITS-1:0];
      REG_INCR:       set_incr  = v[WEIGHT_BITS-1:0];
      REG_START: begin
        // a changed start weight also resets the dry threshold
        if (v[WEIGHT_BITS-1:0] != set_start) begin
          set_start = v[WEIGHT_BITS-1:0];
          dry_w     = v[WEIGHT_BITS-1:0];
        end
      end
      REG_MAX_W:      set_max   = v[WEIGHT_BITS-1:0];
      REG_DRAIN_WAIT: set_wait  = v[TIME_BITS-1:0];
      REG_LIMIT:      set_limit = v[TIME_BITS-1:0];
      REG_DIS_RST:    set_dis   = v[0];
      default: ;
    endcase
  endfunction

  function automatic void flag_field(string name, logic [31:0] e, logic [31:0] a);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
    errors++;
  endfunction

  // most weights are aimed near the threshold that matters in the current mode
  function automatic grams_t pick_weight();
    int aim;
    int spread;
    case ($urandom_range(0, 7))
      0: return grams_t'($urandom);
      1: return $urandom_range(0, 1) ? '1 : '0;
      2: aim = int'(set_max);
      default: begin
        case (pot_mode)
          MODE_WATERING: aim = int'(fill_base) + int'(set_incr);
          MODE_DRAINING: aim = int'(drain_base) - int'(set_drain);
          MODE_DRY:      aim = int'(wet_w);
          default:       aim = int'(dry_w);
        endcase
      end
    endcase
    spread = ($urandom_range(0, 3) == 0) ? 400 : 3;
    aim = aim + int'($urandom_range(0, 2 * spread)) - spread;
    if (aim < 0) aim = 0;
    if (aim > int'({WEIGHT_BITS{1'b1}})) aim = int'({WEIGHT_BITS{1'b1}});
    return grams_t'(aim);
  endfunction

  function automatic in_t make_tick();
    in_t t;
    logic [31:0] raw;
    if ($urandom_range(0, 9) == 0) begin
      raw = $urandom;
      t = raw[$bits(in_t)-1:0];
    end else begin
      t.weight           = pick_weight();
      t.pump_failed      = ($urandom_range(0, 29) == 0);
      t.five_second_mark = ($urandom_range(0, 4) == 0);
      t.disable_req      = ($urandom_range(0, 39) == 0);
      t.start_req        = ($urandom_range(0, 24) == 0);
      t.stop_req         = ($urandom_range(0, 29) == 0);
    end
    return t;
  endfunction

  task automatic write_reg(reg_idx_e sel, logic [DATA_BITS-1:0] v);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    apply_setting(sel, v);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_tick(in_t t, bit typed, out_t w);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 10);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    tick_typed <= typed;
    tick_want  <= w;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    ticks_sent++;
  endtask

  // stop offering and let every outstanding result come back
  task automatic finish_stream();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_phase(int kind);
    logic [DATA_BITS-1:0] vals [8];
    case (kind)
      0: begin
        for (int i = 0; i < 8; i++) vals[i] = '0;
      end
      1: begin
        for (int i = 0; i < 8; i++) vals[i] = DATA_BITS'({WEIGHT_BITS{1'b1}});
      end
      2: begin
        vals[REG_EVAP]       = DATA_BITS'(EVAP_RST);
        vals[REG_DRAIN_TGT]  = DATA_BITS'(DRAIN_TGT_RST);
        vals[REG_INCR]       = DATA_BITS'(INCR_RST);
        vals[REG_START]      = DATA_BITS'(START_RST);
        vals[REG_MAX_W]      = DATA_BITS'(MAX_W_RST);
        vals[REG_DRAIN_WAIT] = DATA_BITS'(DRAIN_WAIT_RST);
        vals[REG_LIMIT]      = DATA_BITS'(LIMIT_RST);
        vals[REG_DIS_RST]    = '0;
      end
      default: begin
        vals[REG_EVAP]       = $urandom_range(0, 3000);
        vals[REG_DRAIN_TGT]  = $urandom_range(0, 800);
        vals[REG_INCR]       = $urandom_range(0, 1500);
        vals[REG_START]      = $urandom_range(500, 12000);
        vals[REG_MAX_W]      = $urandom_range(8000, 40000);
        vals[REG_DRAIN_WAIT] = $urandom_range(0, 6);
        vals[REG_LIMIT]      = $urandom_range(0, 30);
        vals[REG_DIS_RST]    = $urandom_range(0, 1);
      end
    endcase
    for (int i = 0; i < 8; i++) write_reg(reg_idx_e'(i), vals[i]);
    settings_used++;
  endtask

  plan_row_t plan[$];

  function automatic void add_tick(grams_t w, logic [4:0] f, bit typed, out_t w_out);
    plan_row_t r;
    r = '0;
    r.tick  = {w, f};
    r.typed = typed;
    r.want  = w_out;
    plan.push_back(r);
  endfunction

  function automatic void add_write(reg_idx_e sel, logic [DATA_BITS-1:0] v);
    plan_row_t r;
    r = '0;
    r.is_write = 1'b1;
    r.sel      = sel;
    r.value    = v;
    plan.push_back(r);
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, results_due.size());
      $display("FAILURE");
      $finish;
    end
  end

  // request and result monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        calc = advance_pot(in_data_i);
        results_due.push_back(tick_typed ? tick_want : calc);
      end
      if (out_valid_o && !out_stall_i) begin
        if (results_due.size() == 0) begin
          $display("%0t: result with nothing expected, got %h", $time, out_data_o);
          errors++;
        end else begin
          want = results_due.pop_front();
          if (out_data_o.mode_now !== want.mode_now)
            flag_field("mode_now", 32'(want.mode_now), 32'(out_data_o.mode_now));
          if (out_data_o.pump_run !== want.pump_run)
            flag_field("pump_run", 32'(want.pump_run), 32'(out_data_o.pump_run));
          if (out_data_o.pump_disable_pulse !== want.pump_disable_pulse)
            flag_field("pump_disable_pulse", 32'(want.pump_disable_pulse),
                       32'(out_data_o.pump_disable_pulse));
          if (out_data_o.dry_threshold !== want.dry_threshold)
            flag_field("dry_threshold", 32'(want.dry_threshold),
                       32'(out_data_o.dry_threshold));
          if (out_data_o.wet_level !== want.wet_level)
            flag_field("wet_level", 32'(want.wet_level), 32'(out_data_o.wet_level));
          if (out_data_o.mode_now <= MODE_DRAINING) mode_hits[out_data_o.mode_now]++;
          results_checked++;
        end
      end
    end
  end

  initial begin : result_sink
    int unsigned hold;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        hold = LONG_HOLD;
        hold_off_req = 1'b0;
      end else begin
        hold = steady ? 0 : $urandom_range(0, 10);
      end
      @(negedge clk_i);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  initial begin : stimulus
    plan_row_t row;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    tick_typed   = 1'b0;
    tick_want    = '0;
    steady       = 1'b0;
    hold_off_req = 1'b0;
    errors       = 0;
    cycle_count  = 0;
    for (int i = 0; i < 5; i++) mode_hits[i] = 0;

    set_evap   = EVAP_RST;
    set_drain  = DRAIN_TGT_RST;
    set_incr   = INCR_RST;
    set_start  = START_RST;
    set_max    = MAX_W_RST;
    set_wait   = DRAIN_WAIT_RST;
    set_limit  = LIMIT_RST;
    set_dis    = 1'b0;
    pot_mode   = MODE_IDLE;
    dry_w      = START_RST;
    wet_w      = WET_RST;
    fill_base  = '0;
    drain_base = '0;
    drain_held = 1'b0;
    secs_in_mode = '0;
    pump_secs  = '0;
    pump_total = '0;
    pump_flag  = 1'b0;
    dis_pulse  = 1'b0;

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    add_tick(16'd10000, F_NONE, 1'b1, AT_REST);
    add_tick(16'hFFFF, F_FIVE, 1'b1, AT_REST);
    add_tick(16'd0, F_DIS, 1'b1, OFF_PULSE);
    add_tick(16'd0, F_DIS | F_FIVE, 1'b1, OFF_QUIET);
    add_tick(16'd10000, F_STOP, 1'b1, AT_REST);
    add_write(REG_DRAIN_WAIT, 0);
    add_write(REG_LIMIT, 3);
    add_tick(16'd10000, F_START, 1'b1, FILLING);
    add_tick(16'd10500, F_NONE, 1'b1, SOAKING);
    // heavier than the drain start: nothing drained, back to watering
    add_tick(16'd10600, F_NONE, 1'b0, '0);
    add_tick(16'd11100, F_NONE, 1'b0, '0);
    add_tick(16'd10000, F_NONE, 1'b0, '0);
    add_tick(16'd9000, F_FIVE, 1'b0, '0);
    add_tick(16'd9000, F_FAIL, 1'b0, '0);
    add_tick(16'd10000, F_FIVE, 1'b0, '0);
    add_tick(16'd0, F_START | F_FAIL, 1'b0, '0);
    add_tick(16'd0, F_STOP, 1'b0, '0);
    // pump time runs past the limit
    for (int i = 0; i < 4; i++) add_tick(16'd0, F_NONE, 1'b0, '0);
    add_tick(16'hFFFF, F_STOP, 1'b0, '0);
    add_tick(16'd20000, F_START, 1'b0, '0);
    // zero max weight makes idle and watering chase each other
    add_write(REG_MAX_W, 0);
    add_tick(16'd0, F_FIVE, 1'b0, '0);
    add_tick(16'd0, F_START, 1'b0, '0);
    add_tick(16'd100, F_DIS | F_START | F_STOP | F_FIVE, 1'b0, '0);
    add_tick(16'hFFFF, F_FAIL | F_FIVE, 1'b0, '0);

    foreach (plan[i]) begin
      row = plan[i];
      if (row.is_write) begin
        finish_stream();
        write_reg(row.sel, row.value);
      end else begin
        send_tick(row.tick, row.typed, row.want);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      finish_stream();
      program_phase(phase);
      steady = (phase % 3 == 1);
      for (int n = 0; n < PHASE_TICKS; n++) begin
        if (phase == 2 && n == 40) hold_off_req = 1'b1;
        if (n == PHASE_TICKS / 2) finish_stream();
        send_tick(make_tick(), 1'b0, '0);
      end
    end

    finish_stream();
    repeat (20) @(posedge clk_i);

    $display("sent %0d ticks under %0d register settings, %0d results checked",
             ticks_sent, settings_used, results_checked);
    $display("modes seen: disabled %0d dry %0d idle %0d watering %0d draining %0d",
             mode_hits[MODE_DISABLED], mode_hits[MODE_DRY], mode_hits[MODE_IDLE],
             mode_hits[MODE_WATERING], mode_hits[MODE_DRAINING]);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
src/wdws_pkg.sv
src/wdws_regs.sv
src/wdws_dpath.sv
src/wdws_ctrl.sv
src/weight_driven_watering_sequencer.sv
sim/weight_driven_watering_sequencer_tb.sv
